// File: hdl/hbd_pkg.sv
`timescale 1ns / 1ps

package hbd_pkg;

  // Rate ring depth and derived widths
  localparam int unsigned HIST_DEPTH = 8;
  localparam int unsigned SLOT_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int unsigned COUNT_W    = $clog2(HIST_DEPTH + 1);

  // Field widths
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned BPM_W    = 16;
  localparam int unsigned PULSE_W  = 16;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // Rate numerator: ms per minute
  localparam int unsigned RATE_NUM = 60000;

  // Sum of the ring and the width of the shared serial divider
  localparam int unsigned SUM_W = $clog2(HIST_DEPTH * RATE_NUM + 1);
  localparam int unsigned DIV_W = SUM_W;
  localparam int unsigned DVSR_W = TIME_W;
  localparam int unsigned BITCNT_W = $clog2(DIV_W);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_THR  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_THR  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_THR = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = CFG_IDX_W'(3);

  // Register reset values
  localparam logic signed [SAMPLE_W-1:0] MAX_THR_RST  = SAMPLE_W'(512000);
  localparam logic signed [SAMPLE_W-1:0] MIN_THR_RST  = SAMPLE_W'(25600);
  localparam logic signed [SAMPLE_W-1:0] FALL_THR_RST = SAMPLE_W'(0);
  localparam logic [PULSE_W-1:0]         MIN_PULSE_RST = PULSE_W'(250);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]          time_ms;
  } in_t;

  typedef struct packed {
    logic             beat;
    logic [BPM_W-1:0] bpm;
  } out_t;

endpackage

// File: hdl/heartbeat_detector_bpm_top.sv
`timescale 1ns / 1ps

// Channel | Ports                          | Transfer when
// --------+--------------------------------+--------------------------
// input   | in_valid, in_stall, in_data    | in_valid && !in_stall
// result  | out_valid, out_stall, out_data | out_valid && !out_stall
// config  | cfg_we, cfg_idx, cfg_wdata     | cfg_we
//
// A beat-closing item runs a bit-serial divider for 60000/interval, stores the
// rate, sums the ring one entry per cycle, then divides sum/fill_count. Any
// other item goes straight to the result push.
// Synchronous reset (rst_n low) restores register defaults, idle phase and zero
// last beat time, slot and fill count; the ring contents are not cleared.
// Under out_stall the next result waits in a holding register, in_stall high.

module heartbeat_detector_bpm_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  hbd_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output hbd_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [hbd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [hbd_pkg::CFG_W-1:0]     cfg_wdata
);

  import hbd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_RATE,
    S_STORE,
    S_SUM,
    S_DIV_MEAN,
    S_PUSH
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PEAK,
    PH_DOWN
  } phase_t;

  // control state
  state_t                st_r, st_nxt;
  phase_t                phase_r, phase_nxt;
  logic [TIME_W-1:0]     last_r, last_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [COUNT_W-1:0]    fill_r, fill_nxt;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic [BITCNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // registers
  logic signed [SAMPLE_W-1:0] max_thr_r, min_thr_r, fall_thr_r;
  logic [PULSE_W-1:0]         min_pulse_r;

  // datapath
  logic [DIV_W-1:0]  qd_r, qd_nxt;     // dividend in, quotient out
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DVSR_W-1:0] dvsr_r, dvsr_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  out_t              res_r, res_nxt;
  out_t              out_r, out_nxt;

  // rate ring
  logic [BPM_W-1:0]  hist [HIST_DEPTH];
  logic              hist_we;
  logic [BPM_W-1:0]  hist_wdata;
  logic [BPM_W-1:0]  hist_rd_r;

  // divider step
  logic [DIV_W:0]    rem_sh;
  logic [DVSR_W-1:0] rem_diff;
  logic              div_ge;
  logic [DIV_W-1:0]  rem_step, qd_step;

  logic [TIME_W-1:0] interval;
  logic              in_xfer;

  assign in_stall  = (st_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign interval  = in_data.time_ms - last_r;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh   = {rem_r, qd_r[DIV_W-1]};
  assign div_ge   = DVSR_W'(rem_sh) >= dvsr_r;
  assign rem_diff = DVSR_W'(rem_sh) - dvsr_r;
  assign rem_step = div_ge ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
  assign qd_step  = {qd_r[DIV_W-2:0], div_ge};

  always_comb begin
    st_nxt        = st_r;
    phase_nxt     = phase_r;
    last_nxt      = last_r;
    slot_nxt      = slot_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    bit_cnt_nxt   = bit_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    qd_nxt        = qd_r;
    rem_nxt       = rem_r;
    dvsr_nxt      = dvsr_r;
    sum_nxt       = sum_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    hist_we       = 1'b0;
    hist_wdata    = (dvsr_r == '0) ? '0 : qd_r[BPM_W-1:0];

    case (st_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_nxt = '0;
          st_nxt  = S_PUSH;
          if (in_data.sample > max_thr_r) begin
            // over-range: restart detection
            phase_nxt = PH_IDLE;
            last_nxt  = '0;
          end else begin
            case (phase_r)
              PH_PEAK: begin
                if (interval < TIME_W'(min_pulse_r)) begin
                  phase_nxt = PH_IDLE;
                end else begin
                  phase_nxt   = PH_DOWN;
                  last_nxt    = in_data.time_ms;
                  if (fill_r < COUNT_W'(HIST_DEPTH)) begin
                    fill_nxt = fill_r + COUNT_W'(1);
                  end
                  dvsr_nxt    = interval;
                  qd_nxt      = DIV_W'(RATE_NUM);
                  rem_nxt     = '0;
                  bit_cnt_nxt = BITCNT_W'(DIV_W - 1);
                  st_nxt      = S_DIV_RATE;
                end
              end
              PH_DOWN: begin
                if (in_data.sample <= fall_thr_r) begin
                  phase_nxt = PH_IDLE;
                end
              end
              default: begin
                phase_nxt = (in_data.sample > min_thr_r) ? PH_PEAK : PH_IDLE;
              end
            endcase
          end
        end
      end
      S_DIV_RATE: begin
        qd_nxt      = qd_step;
        rem_nxt     = rem_step;
        bit_cnt_nxt = bit_cnt_r - BITCNT_W'(1);
        if (bit_cnt_r == '0) begin
          st_nxt = S_STORE;
        end
      end
      S_STORE: begin
        // zero interval stores rate 0
        hist_we  = 1'b1;
        slot_nxt = (slot_r == SLOT_W'(HIST_DEPTH - 1)) ? '0 : slot_r + SLOT_W'(1);
        cnt_nxt  = '0;
        sum_nxt  = '0;
        st_nxt   = S_SUM;
      end
      S_SUM: begin
        if (cnt_r < fill_r) begin
          sum_nxt = sum_r + SUM_W'(hist_rd_r);
          cnt_nxt = cnt_r + COUNT_W'(1);
        end else begin
          dvsr_nxt    = DVSR_W'(fill_r);
          qd_nxt      = sum_r;
          rem_nxt     = '0;
          bit_cnt_nxt = BITCNT_W'(DIV_W - 1);
          st_nxt      = S_DIV_MEAN;
        end
      end
      S_DIV_MEAN: begin
        qd_nxt      = qd_step;
        rem_nxt     = rem_step;
        bit_cnt_nxt = bit_cnt_r - BITCNT_W'(1);
        if (bit_cnt_r == '0) begin
          res_nxt.beat = 1'b1;
          res_nxt.bpm  = qd_step[BPM_W-1:0];
          st_nxt       = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          st_nxt        = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      phase_r     <= PH_IDLE;
      last_r      <= '0;
      slot_r      <= '0;
      fill_r      <= '0;
      cnt_r       <= '0;
      bit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      max_thr_r   <= MAX_THR_RST;
      min_thr_r   <= MIN_THR_RST;
      fall_thr_r  <= FALL_THR_RST;
      min_pulse_r <= MIN_PULSE_RST;
    end else begin
      st_r        <= st_nxt;
      phase_r     <= phase_nxt;
      last_r      <= last_nxt;
      slot_r      <= slot_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MAX_THR:   max_thr_r   <= SAMPLE_W'(cfg_wdata);
          CFG_MIN_THR:   min_thr_r   <= SAMPLE_W'(cfg_wdata);
          CFG_FALL_THR:  fall_thr_r  <= SAMPLE_W'(cfg_wdata);
          CFG_MIN_PULSE: min_pulse_r <= cfg_wdata[PULSE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    qd_r   <= qd_nxt;
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
    sum_r  <= sum_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  // ring: registered read at the next sum index, write-first on a collision
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist[slot_r] <= hist_wdata;
    end
    if (hist_we && (slot_r == cnt_nxt[SLOT_W-1:0])) begin
      hist_rd_r <= hist_wdata;
    end else begin
      hist_rd_r <= hist[cnt_nxt[SLOT_W-1:0]];
    end
  end

`ifndef SYNTHESIS
  a_no_beat_zero_bpm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.beat) |-> (out_r.bpm == '0))
    else $error("result without beat carries nonzero bpm");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= COUNT_W'(HIST_DEPTH))
    else $error("fill count beyond ring depth");

  a_sum_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SUM) |-> (fill_r != '0))
    else $error("summing an empty ring");

  a_push_after_mean: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DIV_MEAN && bit_cnt_r == '0) |=> (st_r == S_PUSH && res_r.beat))
    else $error("mean division did not hand over a beat result");
`endif

endmodule
